@@ rtl/core/brtm_pkg.sv @@
package brtm_pkg;

   localparam int INNER_POOL = 64;
   localparam int LEAF_POOL  = 64;
   localparam int FANOUT     = 256;
   localparam int NODE_W     = $clog2(INNER_POOL > LEAF_POOL ? INNER_POOL : LEAF_POOL);
   localparam int SLOT_W     = $clog2(FANOUT);
   localparam int ADDR_W     = NODE_W + SLOT_W;
   localparam int PTR_W      = NODE_W + 1;
   localparam int CNT_W      = NODE_W + 1;
   localparam int LEAF_W     = 33;

   localparam logic [2:0] ACT_SET   = 3'd0;
   localparam logic [2:0] ACT_DEL   = 3'd1;
   localparam logic [2:0] ACT_GET   = 3'd2;
   localparam logic [2:0] ACT_HAS   = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] old_value;
      logic        was_present;
      logic        pool_full;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_INNER_RD,
      S_INNER_EV,
      S_ALLOC,
      S_LEAF_RD,
      S_LEAF_EV,
      S_FIN
   } state_type;

   function automatic logic [2:0] depth_of(input logic [2:0] kb);
      logic [2:0] d;
      if (kb == 3'd0) begin
         d = 3'd1;
      end else if (kb > 3'd4) begin
         d = 3'd4;
      end else begin
         d = kb;
      end
      return d;
   endfunction

endpackage

@@ rtl/core/brtm_ram.sv @@
module brtm_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/core/byte_radix_trie_map.sv @@
// channel  | ports                           | direction
// req      | req_valid req_stall req_data    | in
// rsp      | rsp_valid rsp_stall rsp_data    | out
// csr      | csr_we csr_wdata                | in (key_bytes)
// A lookup does one read then one evaluate per inner trie level
// on a single-port-read node memory, then the leaf read and evaluate.
// Each node allocated by set adds a wipe of its row.
// Reset, clear and a key_bytes write start a wipe of the root; no beat
// is taken meanwhile. A new beat is taken while the last result waits on rsp_stall.
module byte_radix_trie_map (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  brtm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output brtm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_wdata
);
   import brtm_pkg::*;

   state_type         state_ff, state_in;
   logic [2:0]        kb_ff, kb_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic              clr_pend_ff, clr_pend_in;
   logic [CNT_W-1:0]  inner_used_ff, inner_used_in;
   logic [CNT_W-1:0]  leaves_used_ff, leaves_used_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [1:0]        rem_ff, rem_in;
   logic [SLOT_W-1:0] sweep_ff, sweep_in;
   logic [NODE_W-1:0] row_ff, row_in;
   logic              wipe_leaf_ff, wipe_leaf_in;
   logic              wipe_inner_ff, wipe_inner_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              in_we, lf_we;
   logic [ADDR_W-1:0] in_waddr, lf_waddr, in_raddr, lf_raddr;
   logic [PTR_W-1:0]  in_wdata, in_rdata;
   logic [LEAF_W-1:0] lf_wdata, lf_rdata;

   logic [2:0]        depth;
   logic [SLOT_W-1:0] kbyte;
   logic              last;
   logic              accept;

   brtm_ram #(.WIDTH(PTR_W), .ADDR_W(ADDR_W)) u_inner (
      .clock (clock),
      .we    (in_we),
      .waddr (in_waddr),
      .wdata (in_wdata),
      .raddr (in_raddr),
      .rdata (in_rdata)
   );

   brtm_ram #(.WIDTH(LEAF_W), .ADDR_W(ADDR_W)) u_leaf (
      .clock (clock),
      .we    (lf_we),
      .waddr (lf_waddr),
      .wdata (lf_wdata),
      .raddr (lf_raddr),
      .rdata (lf_rdata)
   );

   assign depth     = depth_of(kb_ff);
   assign last      = (rem_ff == 2'd1);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      unique case (rem_ff)
         2'd3:    kbyte = req_ff.key[31:24];
         2'd2:    kbyte = req_ff.key[23:16];
         default: kbyte = req_ff.key[15:8];
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      kb_in          = kb_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      clr_pend_in    = clr_pend_ff;
      inner_used_in  = inner_used_ff;
      leaves_used_in = leaves_used_ff;
      node_in        = node_ff;
      rem_in         = rem_ff;
      sweep_in       = sweep_ff;
      row_in         = row_ff;
      wipe_leaf_in   = wipe_leaf_ff;
      wipe_inner_in  = wipe_inner_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      in_we          = 1'b0;
      in_waddr       = {row_ff, sweep_ff};
      in_wdata       = '0;
      in_raddr       = {node_ff, kbyte};
      lf_we          = 1'b0;
      lf_waddr       = {row_ff, sweep_ff};
      lf_wdata       = '0;
      lf_raddr       = {node_ff, req_ff.key[7:0]};

      unique case (state_ff)
         S_CLR: begin
            in_we    = 1'b1;
            lf_we    = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SLOT_W'(FANOUT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               res_in      = '0;
               clr_pend_in = 1'b0;
               node_in     = '0;
               rem_in      = 2'(depth - 3'd1);
               if (req_data.action == ACT_CLEAR) begin
                  clr_pend_in = 1'b1;
                  state_in    = S_FIN;
               end else if (req_data.action > ACT_CLEAR) begin
                  state_in = S_FIN;
               end else if (depth == 3'd1) begin
                  state_in = S_LEAF_RD;
               end else begin
                  state_in = S_INNER_RD;
               end
            end
         end
         S_INNER_RD: begin
            state_in = S_INNER_EV;
         end
         S_INNER_EV: begin
            if (in_rdata == '0) begin
               if (req_ff.action != ACT_SET) begin
                  state_in = S_FIN;
               end else if (last && leaves_used_ff >= CNT_W'(LEAF_POOL)) begin
                  res_in.pool_full = 1'b1;
                  state_in         = S_FIN;
               end else if (!last && inner_used_ff >= CNT_W'(INNER_POOL)) begin
                  res_in.pool_full = 1'b1;
                  state_in         = S_FIN;
               end else begin
                  in_we    = 1'b1;
                  in_waddr = {node_ff, kbyte};
                  sweep_in = '0;
                  state_in = S_ALLOC;
                  if (last) begin
                     in_wdata       = PTR_W'(leaves_used_ff + 1'b1);
                     row_in         = leaves_used_ff[NODE_W-1:0];
                     leaves_used_in = leaves_used_ff + 1'b1;
                     wipe_leaf_in   = 1'b1;
                     wipe_inner_in  = 1'b0;
                  end else begin
                     in_wdata      = PTR_W'(inner_used_ff);
                     row_in        = inner_used_ff[NODE_W-1:0];
                     inner_used_in = inner_used_ff + 1'b1;
                     wipe_leaf_in  = 1'b0;
                     wipe_inner_in = 1'b1;
                  end
               end
            end else if (last) begin
               if (CNT_W'(in_rdata - 1'b1) >= leaves_used_ff) begin
                  state_in = S_FIN;
               end else begin
                  node_in  = NODE_W'(in_rdata - 1'b1);
                  state_in = S_LEAF_RD;
               end
            end else begin
               if (CNT_W'(in_rdata) >= inner_used_ff) begin
                  state_in = S_FIN;
               end else begin
                  node_in  = in_rdata[NODE_W-1:0];
                  rem_in   = rem_ff - 2'd1;
                  state_in = S_INNER_RD;
               end
            end
         end
         S_ALLOC: begin
            in_we    = wipe_inner_ff;
            lf_we    = wipe_leaf_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SLOT_W'(FANOUT - 1)) begin
               node_in = row_ff;
               if (wipe_leaf_ff) begin
                  state_in = S_LEAF_RD;
               end else begin
                  rem_in   = rem_ff - 2'd1;
                  state_in = S_INNER_RD;
               end
            end
         end
         S_LEAF_RD: begin
            state_in = S_LEAF_EV;
         end
         S_LEAF_EV: begin
            res_in.old_value   = lf_rdata[31:0];
            res_in.was_present = lf_rdata[32];
            lf_waddr           = {node_ff, req_ff.key[7:0]};
            if (req_ff.action == ACT_SET) begin
               lf_we    = 1'b1;
               lf_wdata = {1'b1, req_ff.value};
            end else if (req_ff.action == ACT_DEL) begin
               lf_we = 1'b1;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (clr_pend_ff) begin
                  sweep_in       = '0;
                  row_in         = '0;
                  inner_used_in  = CNT_W'(1);
                  leaves_used_in = (depth == 3'd1) ? CNT_W'(1) : '0;
                  state_in       = S_CLR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_CLR;
      endcase

      if (csr_we) begin
         kb_in          = csr_wdata;
         sweep_in       = '0;
         row_in         = '0;
         inner_used_in  = CNT_W'(1);
         leaves_used_in = (depth_of(csr_wdata) == 3'd1) ? CNT_W'(1) : '0;
         state_in       = S_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         kb_ff          <= 3'd4;
         clr_pend_ff    <= 1'b0;
         inner_used_ff  <= CNT_W'(1);
         leaves_used_ff <= '0;
         sweep_ff       <= '0;
         row_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kb_ff          <= kb_in;
         clr_pend_ff    <= clr_pend_in;
         inner_used_ff  <= inner_used_in;
         leaves_used_ff <= leaves_used_in;
         sweep_ff       <= sweep_in;
         row_ff         <= row_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff        <= req_in;
      res_ff        <= res_in;
      node_ff       <= node_in;
      rem_ff        <= rem_in;
      wipe_leaf_ff  <= wipe_leaf_in;
      wipe_inner_ff <= wipe_inner_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_inner_range: assert property (@(posedge clock) disable iff (reset)
      inner_used_ff >= CNT_W'(1) && inner_used_ff <= CNT_W'(INNER_POOL))
      else $error("inner node count out of range");

   a_leaf_range: assert property (@(posedge clock) disable iff (reset)
      leaves_used_ff <= CNT_W'(LEAF_POOL))
      else $error("leaf count out of range");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pool_full |-> !rsp_data.was_present && rsp_data.old_value == '0)
      else $error("failed set reports stale data");

   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR || state_ff == S_ALLOC) |-> req_stall)
      else $error("beat taken during wipe");
`endif

endmodule
